// File: hw/rtl/dac_pkg.sv
// dac_pkg: shared types and constants of the decimal accumulator machine
// used by the controller, the datapath and the top level; no dependencies

package dac_pkg;

   localparam int MemWords  = 100;
   localparam int AddrBits  = 7;
   localparam int WordBits  = 15;
   localparam int AccBits   = 28;
   localparam int StatBits  = 3;
   localparam int TypeBits  = 2;

   // request stream: address then data_value, padded to whole bytes
   localparam int InBits    = 24;
   // result stream: status, write_valid, write_value, program_counter,
   // acc_value, instr_word, read_data, padded to whole bytes
   localparam int RspBits   = StatBits + 1 + WordBits + AddrBits + AccBits
                              + WordBits + WordBits;
   localparam int OutBits   = 88;

   localparam logic signed [WordBits-1:0] WordMax = 15'sd9999;
   localparam logic signed [WordBits-1:0] WordMin = -15'sd9999;
   localparam logic signed [AccBits-1:0]  AccMax  = 28'sd9999;
   localparam logic signed [AccBits-1:0]  AccMin  = -28'sd9999;

   // divide by 100 as a multiply by the scaled reciprocal
   localparam int RecipMul   = 5243;
   localparam int RecipShift = 19;
   localparam int DecProdBits = 27;

   localparam logic [AddrBits-1:0] OP_READ   = 7'd10;
   localparam logic [AddrBits-1:0] OP_WRITE  = 7'd11;
   localparam logic [AddrBits-1:0] OP_LOAD   = 7'd20;
   localparam logic [AddrBits-1:0] OP_STORE  = 7'd21;
   localparam logic [AddrBits-1:0] OP_ADD    = 7'd30;
   localparam logic [AddrBits-1:0] OP_SUB    = 7'd31;
   localparam logic [AddrBits-1:0] OP_DIV    = 7'd32;
   localparam logic [AddrBits-1:0] OP_MUL    = 7'd33;
   localparam logic [AddrBits-1:0] OP_BRANCH = 7'd40;
   localparam logic [AddrBits-1:0] OP_BRNEG  = 7'd41;
   localparam logic [AddrBits-1:0] OP_BRZERO = 7'd42;
   localparam logic [AddrBits-1:0] OP_HALT   = 7'd43;

   localparam logic [StatBits-1:0] ST_RUN   = 3'd0;
   localparam logic [StatBits-1:0] ST_HALT  = 3'd1;
   localparam logic [StatBits-1:0] ST_DIVZ  = 3'd2;
   localparam logic [StatBits-1:0] ST_BADOP = 3'd3;
   localparam logic [StatBits-1:0] ST_OVF   = 3'd4;
   localparam logic [StatBits-1:0] ST_IDLE  = 3'd5;

   typedef enum logic [TypeBits-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_START = 2'd1,
      REQ_EXEC  = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      OPK_READ, OPK_WRITE, OPK_LOAD, OPK_STORE, OPK_ADD, OPK_SUB, OPK_DIV,
      OPK_MUL, OPK_BRANCH, OPK_BRNEG, OPK_BRZERO, OPK_HALT, OPK_BAD
   } op_kind_type;

   typedef enum logic [1:0] {
      RDS_REQ,
      RDS_PC,
      RDS_OPD
   } rd_sel_type;

   typedef struct packed {
      logic       capture;
      logic       load_word;
      logic       start_run;
      rd_sel_type rd_sel;
      logic       read_rsp;
      logic       decode;
      logic       exec;
      logic       div_start;
      logic       div_finish;
      logic       check_ovf;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic running;
      logic div_go;
      logic div_done;
   } sts_type;

endpackage

// File: hw/rtl/decimal_accumulator_cpu.sv
// decimal_accumulator_cpu: one request at a time; a memory read goes through
// address and data states, an executed instruction through fetch, decode, operand,
// execute and check, a divide also through the bit-serial divider; next request
// is taken the cycle after its result enters the output register. synchronous
// active-high reset: memory reads as zero, accumulator, counter and instruction
// cleared, status not started. depends on dac_pkg, dac_ctrl and dac_datapath

module decimal_accumulator_cpu (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // address [6:0], data_value [21:7], zero pad [23:22]
   input  logic [dac_pkg::InBits-1:0]    req_tdata,
   // req_type [1:0]
   input  logic [dac_pkg::TypeBits-1:0]  req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // status [2:0], write_valid [3], write_value [18:4], program_counter [25:19],
   // acc_value [53:26], instr_word [68:54], read_data [83:69], zero pad [87:84]
   output logic [dac_pkg::OutBits-1:0]   rsp_tdata
);

   dac_pkg::cmd_type cmd;
   dac_pkg::sts_type sts;

   dac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dac_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// File: hw/rtl/dac_ram.sv
// dac_ram: generic single-write, single-read memory with registered read data
// no dependencies

module dac_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/dac_div.sv
// dac_div: signed truncating divider, one quotient bit per cycle
// depends on dac_pkg for the word width

module dac_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [dac_pkg::WordBits-1:0]  dividend,
   input  logic signed [dac_pkg::WordBits-1:0]  divisor,
   output logic                                 done,
   output logic signed [dac_pkg::WordBits-1:0]  quotient
);

   localparam int MagBits = dac_pkg::WordBits - 1;
   localparam int CntBits = $clog2(MagBits + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CntBits-1:0]    cnt_ff;
   logic [MagBits-1:0]    rem_ff;
   logic [MagBits-1:0]    quo_ff;
   logic [MagBits-1:0]    den_ff;
   logic                  neg_ff;

   logic [dac_pkg::WordBits-1:0] dvd_abs;
   logic [dac_pkg::WordBits-1:0] dvs_abs;
   logic [MagBits:0]             rem_sh;
   logic [MagBits+1:0]           diff;
   logic                         take;
   logic [MagBits-1:0]           quo_pos;

   assign dvd_abs = dividend[dac_pkg::WordBits-1] ? -dividend : dividend;
   assign dvs_abs = divisor[dac_pkg::WordBits-1] ? -divisor : divisor;

   // restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_sh = {rem_ff, quo_ff[MagBits-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};
   assign take   = ~diff[MagBits+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntBits'(MagBits);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntBits'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dvd_abs[MagBits-1:0];
         den_ff <= dvs_abs[MagBits-1:0];
         neg_ff <= dividend[dac_pkg::WordBits-1] ^ divisor[dac_pkg::WordBits-1];
      end else if (busy_ff) begin
         rem_ff <= take ? diff[MagBits-1:0] : rem_sh[MagBits-1:0];
         quo_ff <= {quo_ff[MagBits-2:0], take};
      end
   end

   assign quo_pos  = quo_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_pos}) : $signed({1'b0, quo_pos});
   assign done     = done_ff;

endmodule

// File: hw/rtl/dac_datapath.sv
// dac_datapath: word memory, accumulator, counter, instruction decode and
// result register; depends on dac_pkg, dac_ram and dac_div

module dac_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  dac_pkg::cmd_type               cmd,
   input  logic [dac_pkg::InBits-1:0]     req_tdata,
   output dac_pkg::sts_type               sts,
   output logic [dac_pkg::OutBits-1:0]    rsp_tdata
);

   localparam int AB = dac_pkg::AddrBits;
   localparam int WB = dac_pkg::WordBits;
   localparam int XB = dac_pkg::AccBits;
   localparam int MB = WB - 1;

   // architectural state
   logic signed [XB-1:0]          acc_ff, acc_in;
   logic [AB-1:0]                 pc_ff, pc_in;
   logic signed [WB-1:0]          instr_ff, instr_in;
   logic [dac_pkg::StatBits-1:0]  status_ff, status_in;
   logic [dac_pkg::MemWords-1:0]  valid_ff;
   logic                          vld_rd_ff;

   // per-request and decode registers
   logic [AB-1:0]                 addr_ff, addr_in;
   logic signed [WB-1:0]          dval_ff, dval_in;
   dac_pkg::op_kind_type          op_ff, op_in;
   logic [AB-1:0]                 opd_ff, opd_in;
   logic                          wvalid_ff, wvalid_in;
   logic signed [WB-1:0]          wvalue_ff, wvalue_in;
   logic signed [WB-1:0]          rdata_ff, rdata_in;
   logic [dac_pkg::OutBits-1:0]   rsp_ff;

   // memory port
   logic                          wr_en;
   logic [AB-1:0]                 wr_addr;
   logic [WB-1:0]                 wr_data;
   logic [AB-1:0]                 rd_addr;
   logic [WB-1:0]                 ram_q;
   logic signed [WB-1:0]          rd_word;

   // decode
   logic                          dec_neg;
   logic [MB-1:0]                 dec_mag;
   logic [dac_pkg::DecProdBits-1:0] dec_prod;
   logic [AB-1:0]                 dec_op;
   logic [MB-1:0]                 dec_hund;
   logic [MB-1:0]                 dec_sub;
   dac_pkg::op_kind_type          dec_kind;

   logic [AB-1:0]                 pc_adv;
   logic signed [WB-1:0]          dval_sat;
   logic signed [2*WB-1:0]        mul_p;
   logic                          load_ok;
   logic                          div_done;
   logic signed [WB-1:0]          div_q;

   dac_ram #(
      .Width (WB),
      .Depth (dac_pkg::MemWords)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   dac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (acc_ff[WB-1:0]),
      .divisor  (rd_word),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      unique case (cmd.rd_sel)
         dac_pkg::RDS_REQ: rd_addr = addr_ff;
         dac_pkg::RDS_PC:  rd_addr = pc_ff;
         dac_pkg::RDS_OPD: rd_addr = opd_ff;
         default:          rd_addr = opd_ff;
      endcase
   end

   // words never written read as zero, as do addresses past the end
   assign rd_word = vld_rd_ff ? $signed(ram_q) : '0;

   assign dec_neg  = rd_word[WB-1];
   assign dec_mag  = rd_word[MB-1:0];
   assign dec_prod = dac_pkg::DecProdBits'(dec_mag) *
                     dac_pkg::DecProdBits'(dac_pkg::RecipMul);
   assign dec_op   = dec_prod[dac_pkg::RecipShift +: AB];
   assign dec_hund = MB'(dec_op) * MB'(100);
   assign dec_sub  = dec_mag - dec_hund;

   always_comb begin
      if (dec_neg) begin
         dec_kind = dac_pkg::OPK_BAD;
      end else begin
         unique case (dec_op)
            dac_pkg::OP_READ:   dec_kind = dac_pkg::OPK_READ;
            dac_pkg::OP_WRITE:  dec_kind = dac_pkg::OPK_WRITE;
            dac_pkg::OP_LOAD:   dec_kind = dac_pkg::OPK_LOAD;
            dac_pkg::OP_STORE:  dec_kind = dac_pkg::OPK_STORE;
            dac_pkg::OP_ADD:    dec_kind = dac_pkg::OPK_ADD;
            dac_pkg::OP_SUB:    dec_kind = dac_pkg::OPK_SUB;
            dac_pkg::OP_DIV:    dec_kind = dac_pkg::OPK_DIV;
            dac_pkg::OP_MUL:    dec_kind = dac_pkg::OPK_MUL;
            dac_pkg::OP_BRANCH: dec_kind = dac_pkg::OPK_BRANCH;
            dac_pkg::OP_BRNEG:  dec_kind = dac_pkg::OPK_BRNEG;
            dac_pkg::OP_BRZERO: dec_kind = dac_pkg::OPK_BRZERO;
            dac_pkg::OP_HALT:   dec_kind = dac_pkg::OPK_HALT;
            default:            dec_kind = dac_pkg::OPK_BAD;
         endcase
      end
   end

   assign pc_adv = (pc_ff == AB'(dac_pkg::MemWords - 1)) ? '0 : pc_ff + 1'b1;

   always_comb begin
      if (dval_ff > dac_pkg::WordMax) begin
         dval_sat = dac_pkg::WordMax;
      end else if (dval_ff < dac_pkg::WordMin) begin
         dval_sat = dac_pkg::WordMin;
      end else begin
         dval_sat = dval_ff;
      end
   end

   // accumulator is within one word while a run is live
   assign mul_p = $signed(acc_ff[WB-1:0]) * rd_word;

   assign load_ok = (addr_ff < AB'(dac_pkg::MemWords)) &&
                    (dval_ff <= dac_pkg::WordMax) && (dval_ff >= dac_pkg::WordMin);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = opd_ff;
      wr_data = acc_ff[WB-1:0];
      if (cmd.load_word) begin
         wr_en   = load_ok;
         wr_addr = addr_ff;
         wr_data = dval_ff;
      end else if (cmd.exec && op_ff == dac_pkg::OPK_READ) begin
         wr_en   = 1'b1;
         wr_data = dval_sat;
      end else if (cmd.exec && op_ff == dac_pkg::OPK_STORE) begin
         wr_en   = 1'b1;
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      pc_in     = pc_ff;
      instr_in  = instr_ff;
      status_in = status_ff;
      addr_in   = addr_ff;
      dval_in   = dval_ff;
      op_in     = op_ff;
      opd_in    = opd_ff;
      wvalid_in = wvalid_ff;
      wvalue_in = wvalue_ff;
      rdata_in  = rdata_ff;

      if (cmd.capture) begin
         addr_in   = req_tdata[AB-1:0];
         dval_in   = $signed(req_tdata[AB +: WB]);
         wvalid_in = 1'b0;
         wvalue_in = '0;
         rdata_in  = '0;
      end
      if (cmd.start_run) begin
         pc_in     = '0;
         acc_in    = '0;
         status_in = dac_pkg::ST_RUN;
      end
      if (cmd.read_rsp) begin
         rdata_in = rd_word;
      end
      if (cmd.decode) begin
         instr_in = rd_word;
         op_in    = dec_kind;
         opd_in   = dec_sub[AB-1:0];
      end
      if (cmd.exec) begin
         unique case (op_ff)
            dac_pkg::OPK_READ:   pc_in = pc_adv;
            dac_pkg::OPK_WRITE: begin
               wvalid_in = 1'b1;
               wvalue_in = rd_word;
               pc_in     = pc_adv;
            end
            dac_pkg::OPK_LOAD: begin
               acc_in = XB'(rd_word);
               pc_in  = pc_adv;
            end
            dac_pkg::OPK_STORE:  pc_in = pc_adv;
            dac_pkg::OPK_ADD: begin
               acc_in = acc_ff + XB'(rd_word);
               pc_in  = pc_adv;
            end
            dac_pkg::OPK_SUB: begin
               acc_in = acc_ff - XB'(rd_word);
               pc_in  = pc_adv;
            end
            dac_pkg::OPK_DIV: begin
               // nonzero divisor goes to the divider, finished later
               if (rd_word == '0) begin
                  status_in = dac_pkg::ST_DIVZ;
               end
            end
            dac_pkg::OPK_MUL: begin
               acc_in = mul_p[XB-1:0];
               pc_in  = pc_adv;
            end
            dac_pkg::OPK_BRANCH: pc_in = opd_ff;
            dac_pkg::OPK_BRNEG:  pc_in = acc_ff[XB-1] ? opd_ff : pc_adv;
            dac_pkg::OPK_BRZERO: pc_in = (acc_ff == '0) ? opd_ff : pc_adv;
            dac_pkg::OPK_HALT:   status_in = dac_pkg::ST_HALT;
            default:             status_in = dac_pkg::ST_BADOP;
         endcase
      end
      if (cmd.div_finish) begin
         acc_in = XB'(div_q);
         pc_in  = pc_adv;
      end
      if (cmd.check_ovf) begin
         if (acc_ff > dac_pkg::AccMax || acc_ff < dac_pkg::AccMin) begin
            status_in = dac_pkg::ST_OVF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         pc_ff     <= '0;
         instr_ff  <= '0;
         status_ff <= dac_pkg::ST_IDLE;
         valid_ff  <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         pc_ff     <= pc_in;
         instr_ff  <= instr_in;
         status_ff <= status_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld_rd_ff <= (rd_addr < AB'(dac_pkg::MemWords)) ? valid_ff[rd_addr] : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      dval_ff   <= dval_in;
      op_ff     <= op_in;
      opd_ff    <= opd_in;
      wvalid_ff <= wvalid_in;
      wvalue_ff <= wvalue_in;
      rdata_ff  <= rdata_in;
      if (cmd.load_rsp) begin
         rsp_ff <= {(dac_pkg::OutBits - dac_pkg::RspBits)'(0), rdata_ff, instr_ff,
                    acc_ff, pc_ff, wvalue_ff, wvalid_ff, status_ff};
      end
   end

   assign rsp_tdata    = rsp_ff;
   assign sts.running  = (status_ff == dac_pkg::ST_RUN);
   assign sts.div_go   = (op_ff == dac_pkg::OPK_DIV) && (rd_word != '0);
   assign sts.div_done = div_done;

endmodule

// File: hw/rtl/dac_ctrl.sv
// dac_ctrl: sequencer for one request at a time and result handshake
// depends on dac_pkg for the command and status structs

module dac_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dac_pkg::TypeBits-1:0]  req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  dac_pkg::sts_type              sts,
   output dac_pkg::cmd_type              cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_START, S_RD_ADDR, S_RD_DATA, S_FETCH, S_DECODE,
      S_OPND, S_EXEC, S_DIV_START, S_DIV_WAIT, S_DIV_FIN, S_CHECK, S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_tvalid_ff;
   logic      accept;
   logic      rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   // the result register frees up in the same cycle it is taken
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = dac_pkg::RDS_OPD;
      cmd.capture    = accept;
      cmd.load_rsp   = rsp_load;
      unique case (state_ff)
         S_LOAD:      cmd.load_word  = 1'b1;
         S_START:     cmd.start_run  = 1'b1;
         S_RD_ADDR:   cmd.rd_sel     = dac_pkg::RDS_REQ;
         S_RD_DATA: begin
            cmd.rd_sel   = dac_pkg::RDS_REQ;
            cmd.read_rsp = 1'b1;
         end
         S_FETCH:     cmd.rd_sel     = dac_pkg::RDS_PC;
         S_DECODE: begin
            cmd.rd_sel = dac_pkg::RDS_PC;
            cmd.decode = 1'b1;
         end
         S_EXEC:      cmd.exec       = 1'b1;
         S_DIV_START: cmd.div_start  = 1'b1;
         S_DIV_FIN:   cmd.div_finish = 1'b1;
         S_CHECK:     cmd.check_ovf  = 1'b1;
         default:     cmd.rd_sel     = dac_pkg::RDS_OPD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (dac_pkg::req_kind_type'(req_tuser))
                     dac_pkg::REQ_LOAD:  state_ff <= S_LOAD;
                     dac_pkg::REQ_START: state_ff <= S_START;
                     dac_pkg::REQ_EXEC:  state_ff <= sts.running ? S_FETCH : S_DONE;
                     dac_pkg::REQ_READ:  state_ff <= S_RD_ADDR;
                     default:            state_ff <= S_DONE;
                  endcase
               end
            end
            S_LOAD:      state_ff <= S_DONE;
            S_START:     state_ff <= S_DONE;
            S_RD_ADDR:   state_ff <= S_RD_DATA;
            S_RD_DATA:   state_ff <= S_DONE;
            S_FETCH:     state_ff <= S_DECODE;
            S_DECODE:    state_ff <= S_OPND;
            S_OPND:      state_ff <= S_EXEC;
            S_EXEC:      state_ff <= sts.div_go ? S_DIV_START : S_CHECK;
            S_DIV_START: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (sts.div_done) begin
                  state_ff <= S_DIV_FIN;
               end
            end
            S_DIV_FIN:   state_ff <= S_CHECK;
            S_CHECK:     state_ff <= S_DONE;
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default:     state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

// File: tb/sv/decimal_accumulator_cpu_test.sv
// decimal_accumulator_cpu_test: self-checking bench for the decimal accumulator machine,
// with a request sender, a result checker and a request-level predictor of the machine.
// depends on dac_pkg and decimal_accumulator_cpu
`timescale 1ns / 1ps

module decimal_accumulator_cpu_test;

   localparam int DrainCycles = 40;

   // result fields from the top bit down, so the struct lines up with rsp_tdata[83:0]
   typedef struct packed {
      logic [dac_pkg::WordBits-1:0] read_data;
      logic [dac_pkg::WordBits-1:0] instr;
      logic [dac_pkg::AccBits-1:0]  acc;
      logic [dac_pkg::AddrBits-1:0] pc;
      logic [dac_pkg::WordBits-1:0] write_value;
      logic                         write_valid;
      logic [dac_pkg::StatBits-1:0] status;
   } machine_view_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [dac_pkg::InBits-1:0]   req_tdata = '0;
   logic [dac_pkg::TypeBits-1:0] req_tuser = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [dac_pkg::OutBits-1:0]  rsp_tdata;

   // predicted machine state
   logic signed [dac_pkg::WordBits-1:0] word_mem [dac_pkg::MemWords];
   logic signed [dac_pkg::AccBits-1:0]  acc_q;
   logic [dac_pkg::AddrBits-1:0]        pc_q;
   logic signed [dac_pkg::WordBits-1:0] instr_q;
   logic [dac_pkg::StatBits-1:0]        run_state;

   machine_view_type predicted_views[$];
   int requests_sent = 0;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;

   decimal_accumulator_cpu u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // one request through the machine, returns what the result should show
   function automatic machine_view_type step_machine(dac_pkg::req_kind_type kind,
                                                     logic [dac_pkg::AddrBits-1:0] addr,
                                                     logic signed [dac_pkg::WordBits-1:0] dval);
      machine_view_type v;
      int word, opc, opd, operand, acc_i, next_pc, x;
      v = '0;
      case (kind)
         dac_pkg::REQ_LOAD: begin
            if (addr < dac_pkg::MemWords && dval >= dac_pkg::WordMin &&
                dval <= dac_pkg::WordMax) word_mem[addr] = dval;
         end
         dac_pkg::REQ_START: begin
            pc_q = '0;
            acc_q = '0;
            run_state = dac_pkg::ST_RUN;
         end
         dac_pkg::REQ_EXEC: begin
            if (run_state == dac_pkg::ST_RUN) begin
               word = int'(word_mem[pc_q]);
               instr_q = word_mem[pc_q];
               opc = word / 100;
               opd = word % 100;
               // negative words carry a negative operand too
               if (opd < 0) begin
                  opc = -1;
                  opd = 0;
               end
               operand = int'(word_mem[opd]);
               acc_i = int'(acc_q);
               next_pc = (pc_q >= dac_pkg::MemWords - 1) ? 0 : int'(pc_q) + 1;
               case (opc)
                  dac_pkg::OP_READ: begin
                     x = int'(dval);
                     if (x > dac_pkg::WordMax) x = dac_pkg::WordMax;
                     if (x < dac_pkg::WordMin) x = dac_pkg::WordMin;
                     word_mem[opd] = dac_pkg::WordBits'(x);
                     pc_q = dac_pkg::AddrBits'(next_pc);
                  end
                  dac_pkg::OP_WRITE: begin
                     v.write_valid = 1'b1;
                     v.write_value = word_mem[opd];
                     pc_q = dac_pkg::AddrBits'(next_pc);
                  end
                  dac_pkg::OP_LOAD: begin
                     acc_i = operand;
                     pc_q = dac_pkg::AddrBits'(next_pc);
                  end
                  dac_pkg::OP_STORE: begin
                     word_mem[opd] = dac_pkg::WordBits'(acc_i);
                     pc_q = dac_pkg::AddrBits'(next_pc);
                  end
                  dac_pkg::OP_ADD: begin
                     acc_i = acc_i + operand;
                     pc_q = dac_pkg::AddrBits'(next_pc);
                  end
                  dac_pkg::OP_SUB: begin
                     acc_i = acc_i - operand;
                     pc_q = dac_pkg::AddrBits'(next_pc);
                  end
                  dac_pkg::OP_DIV: begin
                     if (operand == 0) begin
                        run_state = dac_pkg::ST_DIVZ;
                     end else begin
                        acc_i = acc_i / operand;
                        pc_q = dac_pkg::AddrBits'(next_pc);
                     end
                  end
                  dac_pkg::OP_MUL: begin
                     acc_i = acc_i * operand;
                     pc_q = dac_pkg::AddrBits'(next_pc);
                  end
                  dac_pkg::OP_BRANCH: pc_q = dac_pkg::AddrBits'(opd);
                  dac_pkg::OP_BRNEG:
                     pc_q = dac_pkg::AddrBits'((acc_i < 0) ? opd : next_pc);
                  dac_pkg::OP_BRZERO:
                     pc_q = dac_pkg::AddrBits'((acc_i == 0) ? opd : next_pc);
                  dac_pkg::OP_HALT: run_state = dac_pkg::ST_HALT;
                  default: run_state = dac_pkg::ST_BADOP;
               endcase
               acc_q = dac_pkg::AccBits'(acc_i);
               if (acc_i < dac_pkg::AccMin || acc_i > dac_pkg::AccMax)
                  run_state = dac_pkg::ST_OVF;
            end
         end
         default: begin
            if (addr < dac_pkg::MemWords) v.read_data = word_mem[addr];
         end
      endcase
      v.status = run_state;
      v.pc = pc_q;
      v.acc = acc_q;
      v.instr = instr_q;
      return v;
   endfunction

   function automatic int pick_gap();
      int g;
      g = 0;
      while (g < 40 && $urandom_range(99) < send_idle_pct) g++;
      return g;
   endfunction

   // called and returns at a falling edge
   task automatic send_request(dac_pkg::req_kind_type kind, int addr, int dval);
      int gap;
      logic [dac_pkg::AddrBits-1:0]        a;
      logic signed [dac_pkg::WordBits-1:0] d;
      a = dac_pkg::AddrBits'(addr);
      d = dac_pkg::WordBits'(dval);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {2'b00, d, a};
      do @(posedge clock); while (!req_tready);
      predicted_views.push_back(step_machine(kind, a, d));
      requests_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drain();
      while (predicted_views.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic load_words(int base, int words[$]);
      foreach (words[i]) send_request(dac_pkg::REQ_LOAD, base + i, words[i]);
   endtask

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         mismatch_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      machine_view_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = machine_view_type'(rsp_tdata[83:0]);
         if (predicted_views.size() == 0) begin
            mismatch_count++;
            $error("result with no request pending: %h", rsp_tdata);
         end else begin
            want = predicted_views.pop_front();
            check_field("status", want.status, got.status);
            check_field("write_valid", want.write_valid, got.write_valid);
            check_field("write_value", $signed(want.write_value), $signed(got.write_value));
            check_field("program_counter", want.pc, got.pc);
            check_field("acc_value", $signed(want.acc), $signed(got.acc));
            check_field("instr_word", $signed(want.instr), $signed(got.instr));
            check_field("read_data", $signed(want.read_data), $signed(got.read_data));
         end
      end
   end

   // receiver: long hold when asked, otherwise random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic int random_word();
      case ($urandom_range(3))
         0: return 0;
         1: return int'($urandom_range(40)) - 20;
         2: return int'($urandom_range(400)) - 200;
         default: return int'($urandom_range(19998)) - 9999;
      endcase
   endfunction

   function automatic int exec_input();
      if ($urandom_range(3) == 0) return int'($urandom_range(32767));
      return int'($urandom_range(19998)) - 9999;
   endfunction

   function automatic int random_instruction(int len);
      int ops[12] = '{dac_pkg::OP_READ, dac_pkg::OP_WRITE, dac_pkg::OP_LOAD,
                      dac_pkg::OP_STORE, dac_pkg::OP_ADD, dac_pkg::OP_SUB,
                      dac_pkg::OP_DIV, dac_pkg::OP_MUL, dac_pkg::OP_BRANCH,
                      dac_pkg::OP_BRNEG, dac_pkg::OP_BRZERO, dac_pkg::OP_HALT};
      int op, opd;
      if ($urandom_range(19) == 0) return int'($urandom_range(19998)) - 9999;
      op = ops[$urandom_range(11)];
      if (op == dac_pkg::OP_BRANCH || op == dac_pkg::OP_BRNEG || op == dac_pkg::OP_BRZERO)
         opd = int'($urandom_range(len - 1));
      else if ($urandom_range(3) == 0) opd = int'($urandom_range(99));
      else opd = 60 + int'($urandom_range(9));
      return op * 100 + opd;
   endfunction

   task automatic test_memory_requests();
      send_request(dac_pkg::REQ_EXEC, 0, 0);
      send_request(dac_pkg::REQ_LOAD, 0, 9999);
      send_request(dac_pkg::REQ_LOAD, 99, -9999);
      send_request(dac_pkg::REQ_LOAD, 127, 1234);
      send_request(dac_pkg::REQ_LOAD, 1, 16383);
      send_request(dac_pkg::REQ_LOAD, 1, -16384);
      send_request(dac_pkg::REQ_READ, 0, 0);
      send_request(dac_pkg::REQ_READ, 99, 0);
      send_request(dac_pkg::REQ_READ, 127, -1);
      send_request(dac_pkg::REQ_READ, 1, 0);
   endtask

   task automatic test_every_opcode();
      int prog[$];
      // read, write, arithmetic, taken and untaken branches, then halt
      prog = {1050, 1150, 2090, 3091, 3191, 3391, 3290, 4109, 4300, 2151, 4211, 2092,
              4214, 4300, 4116, 4017, 4300, 4300};
      load_words(0, prog);
      prog = {7, -3, 0, 9999};
      load_words(90, prog);
      send_request(dac_pkg::REQ_START, 0, 0);
      repeat (15) send_request(dac_pkg::REQ_EXEC, 0, 16383);
      send_request(dac_pkg::REQ_READ, 51, 0);
   endtask

   task automatic test_stop_cases();
      int prog[$];
      // negative saturation on read, then divide by zero
      prog = {1052, 2052, 3292};
      load_words(0, prog);
      send_request(dac_pkg::REQ_START, 0, 0);
      repeat (4) send_request(dac_pkg::REQ_EXEC, 0, -16384);
      // opcode zero, then a negative word
      send_request(dac_pkg::REQ_LOAD, 0, 99);
      send_request(dac_pkg::REQ_START, 0, 0);
      send_request(dac_pkg::REQ_EXEC, 0, 0);
      send_request(dac_pkg::REQ_LOAD, 0, -1050);
      send_request(dac_pkg::REQ_START, 0, 0);
      send_request(dac_pkg::REQ_EXEC, 0, 0);
      // accumulator overflow keeps the value
      prog = {2093, 3093};
      load_words(0, prog);
      send_request(dac_pkg::REQ_START, 0, 0);
      repeat (3) send_request(dac_pkg::REQ_EXEC, 0, 0);
      // counter wraps from 99 to 0
      send_request(dac_pkg::REQ_LOAD, 0, 4099);
      send_request(dac_pkg::REQ_LOAD, 99, 2093);
      send_request(dac_pkg::REQ_START, 0, 0);
      repeat (3) send_request(dac_pkg::REQ_EXEC, 0, 0);
   endtask

   task automatic test_random_programs(int count);
      int stop_at, len, steps, r;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         len = int'($urandom_range(20, 3));
         // sometimes rerun what is already in memory
         if ($urandom_range(4) != 0) begin
            for (int i = 0; i < len; i++)
               send_request(dac_pkg::REQ_LOAD, i, random_instruction(len));
            for (int j = 60; j < 70; j++) begin
               if ($urandom_range(1)) send_request(dac_pkg::REQ_LOAD, j, random_word());
            end
         end
         if ($urandom_range(3) == 0)
            send_request(dac_pkg::REQ_LOAD, int'($urandom_range(127)),
                         int'($urandom_range(32767)));
         send_request(dac_pkg::REQ_START, int'($urandom_range(127)),
                      int'($urandom_range(32767)));
         steps = int'($urandom_range(60, 4));
         for (int s = 0; s < steps && run_state == dac_pkg::ST_RUN; s++) begin
            r = int'($urandom_range(15));
            if (r == 0)
               send_request(dac_pkg::REQ_READ, int'($urandom_range(127)),
                            int'($urandom_range(32767)));
            else if (r == 1)
               send_request(dac_pkg::REQ_LOAD, 60 + int'($urandom_range(9)), random_word());
            else
               send_request(dac_pkg::REQ_EXEC, int'($urandom_range(127)), exec_input());
         end
         if ($urandom_range(7) == 0) send_request(dac_pkg::REQ_EXEC, 0, 0);
      end
   endtask

   task automatic test_receiver_hold();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 300;
      // keep offering requests while results back up
      for (int i = 0; i < 20; i++) begin
         if (i % 3 == 0) send_request(dac_pkg::REQ_READ, int'($urandom_range(99)), 0);
         else send_request(dac_pkg::REQ_LOAD, 60 + int'($urandom_range(9)), random_word());
      end
      wait_drain();
   endtask

   initial begin
      int send_pcts[4] = '{0, 71, 0, 21};
      int stall_pcts[4] = '{0, 0, 71, 21};
      foreach (word_mem[i]) word_mem[i] = '0;
      acc_q = '0;
      pc_q = '0;
      instr_q = '0;
      run_state = dac_pkg::ST_IDLE;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_memory_requests();
      test_every_opcode();
      test_stop_cases();
      wait_drain();
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_pcts[p];
         stall_pct = stall_pcts[p];
         test_random_programs(450);
      end
      test_receiver_hold();

      wait_drain();
      if (mismatch_count == 0) $display("decimal_accumulator_cpu_test: PASS");
      else $display("decimal_accumulator_cpu_test: FAIL");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("decimal_accumulator_cpu_test: FAIL");
      $finish;
   end

endmodule
